// ----- rtl/nsl_pkg.sv -----
// ----------------------------------------------------------------------------
// nsl_pkg
// Shared types and constants for the nearest seed labeler: table size,
// coordinate widths, opcodes, status codes and the seed record layout.
// ----------------------------------------------------------------------------
package nsl_pkg;

    localparam int MAX_SEEDS   = 256;
    localparam int COORD_BITS  = 24;
    localparam int IDX_BITS    = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
    localparam int CNT_BITS    = $clog2(MAX_SEEDS + 1);
    localparam int DX_BITS     = COORD_BITS + 1;
    localparam int SQ_BITS     = 2 * DX_BITS;
    localparam int DIST_BITS   = SQ_BITS + 1;

    // fixed field widths of the ports
    localparam int OPCODE_BITS = 2;
    localparam int SIDX_BITS   = 8;
    localparam int LABEL_BITS  = 9;
    localparam int STATUS_BITS = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 9;
    localparam int COUNT_BITS  = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_SEED_COUNT  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LABEL_BASE  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT_UPD  = 2'd2;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_LOAD     = 2'd0,
        OP_CLASSIFY = 2'd1,
        OP_READ     = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SEEDS = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_WRBACK,
        S_READ
    } t_state;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] h;
    } t_seed;

    // travels with each seed through the distance pipeline
    typedef struct packed {
        logic                valid;
        logic                last;
        logic [IDX_BITS-1:0] idx;
    } t_tag;

endpackage

// ----- rtl/nearest_seed_labeler_max_height.sv -----
// ----------------------------------------------------------------------------
// nearest_seed_labeler_max_height
// Seed table in one RAM; classify scans it for the nearest seed in the plane,
// labels the point and, if height update is on, raises the winner's height to the point's z.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------
//  command  | start, busy, i_opcode .. i_coord_z      | start & !busy
//  result   | o_result_strobe, o_tree_label .. status | strobe, one cycle
//  config   | i_cfg_valid, o_cfg_ready, index, data   | valid & ready
//
//  load, unused opcode, empty classify and out of range: result in the cycle
//  after the transaction; read: a registered RAM read, then the result.
//  classify: one RAM read per seed, three distance stages and the compare,
//  then a winner read and height write back; busy is high until the result.
//  reset is synchronous, active low; the seed RAM is not cleared.
//  results cannot be stalled; busy holds off new commands.
// ----------------------------------------------------------------------------
module nearest_seed_labeler_max_height (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [nsl_pkg::OPCODE_BITS-1:0]        i_opcode,
    input  logic [nsl_pkg::SIDX_BITS-1:0]          i_seed_index,
    input  logic signed [nsl_pkg::COORD_BITS-1:0]  i_coord_x,
    input  logic signed [nsl_pkg::COORD_BITS-1:0]  i_coord_y,
    input  logic signed [nsl_pkg::COORD_BITS-1:0]  i_coord_z,
    output logic                                   o_result_strobe,
    output logic [nsl_pkg::LABEL_BITS-1:0]         o_tree_label,
    output logic signed [nsl_pkg::COORD_BITS-1:0]  o_seed_x_out,
    output logic signed [nsl_pkg::COORD_BITS-1:0]  o_seed_y_out,
    output logic signed [nsl_pkg::COORD_BITS-1:0]  o_seed_height_out,
    output logic [nsl_pkg::STATUS_BITS-1:0]        o_status,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [nsl_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [nsl_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);

    nsl_pkg::t_state                        r_state, n_state;

    // configuration
    logic [nsl_pkg::COUNT_BITS-1:0]         r_seed_count;
    logic                                   r_label_base;
    logic                                   r_height_upd;
    logic [nsl_pkg::CNT_BITS-1:0]           eff_count;

    // point and scan control
    logic signed [nsl_pkg::COORD_BITS-1:0]  r_px, r_py, r_pz;
    logic [nsl_pkg::CNT_BITS-1:0]           r_n;
    logic [nsl_pkg::CNT_BITS-1:0]           r_cnt;
    nsl_pkg::t_tag                          r_tag1, n_tag1;
    logic [nsl_pkg::IDX_BITS-1:0]           r_best_idx;
    logic [nsl_pkg::DIST_BITS-1:0]          r_best_dist;

    // RAM ports
    logic                                   ram_we;
    logic [nsl_pkg::IDX_BITS-1:0]           ram_waddr, ram_raddr;
    nsl_pkg::t_seed                         ram_wdata, ram_rdata;

    // pipeline output
    nsl_pkg::t_tag                          cmp_tag;
    logic [nsl_pkg::DIST_BITS-1:0]          cmp_dist;
    logic                                   take_best;

    // result registers
    logic                                   r_strobe, n_strobe;
    logic [nsl_pkg::LABEL_BITS-1:0]         r_label, n_label;
    nsl_pkg::t_seed                         r_seed_o, n_seed_o;
    nsl_pkg::t_status                       r_status, n_status;

    // command decode
    logic                                   accept;
    logic                                   idx_in_table;
    logic                                   idx_in_count;
    logic                                   issue;
    logic signed [nsl_pkg::COORD_BITS-1:0]  new_height;

    assign accept       = start && !busy;
    assign busy         = (r_state != nsl_pkg::S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign idx_in_table = (32'(i_seed_index) < 32'(nsl_pkg::MAX_SEEDS));
    assign idx_in_count = (32'(i_seed_index) < 32'(eff_count));
    assign issue        = (r_state == nsl_pkg::S_SCAN) && (r_cnt < r_n);
    assign take_best    = cmp_tag.valid
                       && ((cmp_tag.idx == '0) || (cmp_dist < r_best_dist));
    assign new_height   = (r_height_upd && (ram_rdata.h < r_pz)) ? r_pz : ram_rdata.h;

    // saturate seed count at table size
    always_comb begin
        if (32'(r_seed_count) > 32'(nsl_pkg::MAX_SEEDS)) begin
            eff_count = nsl_pkg::CNT_BITS'(nsl_pkg::MAX_SEEDS);
        end else begin
            eff_count = nsl_pkg::CNT_BITS'(r_seed_count);
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_count <= '0;
            r_label_base <= 1'b0;
            r_height_upd <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                nsl_pkg::CFG_SEED_COUNT: r_seed_count <= i_cfg_data;
                nsl_pkg::CFG_LABEL_BASE: r_label_base <= i_cfg_data[0];
                nsl_pkg::CFG_HEIGHT_UPD: r_height_upd <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nsl_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_opcode == nsl_pkg::OP_CLASSIFY && eff_count != '0) begin
                        n_state = nsl_pkg::S_SCAN;
                    end else if (i_opcode == nsl_pkg::OP_READ && idx_in_count) begin
                        n_state = nsl_pkg::S_READ;
                    end
                end
            end
            nsl_pkg::S_SCAN: begin
                if (cmp_tag.valid && cmp_tag.last) begin
                    n_state = nsl_pkg::S_FETCH;
                end
            end
            nsl_pkg::S_FETCH:  n_state = nsl_pkg::S_WRBACK;
            nsl_pkg::S_WRBACK: n_state = nsl_pkg::S_IDLE;
            nsl_pkg::S_READ:   n_state = nsl_pkg::S_IDLE;
            default:           n_state = nsl_pkg::S_IDLE;
        endcase
    end

    // outputs: RAM control, scan issue and result values
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = nsl_pkg::IDX_BITS'(i_seed_index);
        ram_wdata = {i_coord_x, i_coord_y, i_coord_z};
        ram_raddr = nsl_pkg::IDX_BITS'(i_seed_index);
        n_tag1    = '0;
        n_strobe  = 1'b0;
        n_label   = '0;
        n_seed_o  = '0;
        n_status  = nsl_pkg::ST_OK;
        unique case (r_state)
            nsl_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_opcode)
                        nsl_pkg::OP_LOAD: begin
                            n_strobe = 1'b1;
                            if (idx_in_table) begin
                                ram_we   = 1'b1;
                                n_seed_o = {i_coord_x, i_coord_y, i_coord_z};
                            end else begin
                                n_status = nsl_pkg::ST_RANGE;
                            end
                        end
                        nsl_pkg::OP_CLASSIFY: begin
                            if (eff_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = nsl_pkg::ST_NO_SEEDS;
                            end
                        end
                        nsl_pkg::OP_READ: begin
                            if (!idx_in_count) begin
                                n_strobe = 1'b1;
                                n_status = nsl_pkg::ST_RANGE;
                            end
                        end
                        default: n_strobe = 1'b1;
                    endcase
                end
            end
            nsl_pkg::S_SCAN: begin
                ram_raddr    = r_cnt[nsl_pkg::IDX_BITS-1:0];
                n_tag1.valid = issue;
                n_tag1.last  = (r_cnt == r_n - 1'b1);
                n_tag1.idx   = r_cnt[nsl_pkg::IDX_BITS-1:0];
            end
            nsl_pkg::S_FETCH: begin
                ram_raddr = r_best_idx;
            end
            nsl_pkg::S_WRBACK: begin
                ram_we     = 1'b1;
                ram_waddr  = r_best_idx;
                ram_wdata  = {ram_rdata.x, ram_rdata.y, new_height};
                n_strobe   = 1'b1;
                n_label    = nsl_pkg::LABEL_BITS'(r_best_idx)
                           + nsl_pkg::LABEL_BITS'(r_label_base);
                n_seed_o   = {ram_rdata.x, ram_rdata.y, new_height};
            end
            nsl_pkg::S_READ: begin
                n_strobe = 1'b1;
                n_seed_o = ram_rdata;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= nsl_pkg::S_IDLE;
            r_tag1   <= '0;
            r_strobe <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_tag1   <= n_tag1;
            r_strobe <= n_strobe;
            if (accept) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // point latch, running best and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
            r_pz <= i_coord_z;
            r_n  <= eff_count;
        end
        if (take_best) begin
            r_best_idx  <= cmp_tag.idx;
            r_best_dist <= cmp_dist;
        end
        r_label  <= n_label;
        r_seed_o <= n_seed_o;
        r_status <= n_status;
    end

    nsl_ram #(
        .WIDTH ($bits(nsl_pkg::t_seed)),
        .DEPTH (nsl_pkg::MAX_SEEDS)
    ) u_seed_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    nsl_dist_pipe u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag1),
        .i_seed  (ram_rdata),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_tag   (cmp_tag),
        .o_dist  (cmp_dist)
    );

    assign o_result_strobe   = r_strobe;
    assign o_tree_label      = r_label;
    assign o_seed_x_out      = r_seed_o.x;
    assign o_seed_y_out      = r_seed_o.y;
    assign o_seed_height_out = r_seed_o.h;
    assign o_status          = r_status;

`ifndef SYNTHESIS
    // empty table classify answers next cycle with no-seeds status
    a_empty_classify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == nsl_pkg::OP_CLASSIFY && eff_count == '0)
        |=> (o_result_strobe && o_status == nsl_pkg::ST_NO_SEEDS))
        else $error("empty classify gave no no-seeds result");

    // no table writes while the scan reads it
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nsl_pkg::S_SCAN) |-> !ram_we)
        else $error("seed table written during scan");

    // write back always produces the result and frees the block
    a_wrback_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nsl_pkg::S_WRBACK) |=> (o_result_strobe && !busy))
        else $error("write back without result");

    // the winner lies inside the searched range
    a_best_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nsl_pkg::S_FETCH)
        |-> (nsl_pkg::CNT_BITS'(r_best_idx) < r_n))
        else $error("winner index beyond seed count");
`endif

endmodule

// ----- rtl/nsl_ram.sv -----
// ----------------------------------------------------------------------------
// nsl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module nsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/nsl_dist_pipe.sv -----
// ----------------------------------------------------------------------------
// nsl_dist_pipe
// Three stage squared planar distance: difference, square, sum. The seed
// tag rides along so the compare stage knows index and end of scan.
// ----------------------------------------------------------------------------
module nsl_dist_pipe (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  nsl_pkg::t_tag                          i_tag,
    input  nsl_pkg::t_seed                         i_seed,
    input  logic signed [nsl_pkg::COORD_BITS-1:0]  i_px,
    input  logic signed [nsl_pkg::COORD_BITS-1:0]  i_py,
    output nsl_pkg::t_tag                          o_tag,
    output logic [nsl_pkg::DIST_BITS-1:0]          o_dist
);

    nsl_pkg::t_tag                        r_tag2, r_tag3, r_tag4;
    logic signed [nsl_pkg::DX_BITS-1:0]   r_dx, r_dy;
    logic signed [nsl_pkg::SQ_BITS-1:0]   r_sqx, r_sqy;
    logic [nsl_pkg::DIST_BITS-1:0]        r_dist;
    logic signed [nsl_pkg::DX_BITS-1:0]   n_dx, n_dy;

    // sign extended differences
    always_comb begin
        n_dx = nsl_pkg::DX_BITS'(i_px) - nsl_pkg::DX_BITS'(i_seed.x);
        n_dy = nsl_pkg::DX_BITS'(i_py) - nsl_pkg::DX_BITS'(i_seed.y);
    end

    // tag registers, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_tag4 <= '0;
        end else begin
            r_tag2 <= i_tag;
            r_tag3 <= r_tag2;
            r_tag4 <= r_tag3;
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_sqx  <= r_dx * r_dx;
        r_sqy  <= r_dy * r_dy;
        r_dist <= nsl_pkg::DIST_BITS'($unsigned(r_sqx))
                + nsl_pkg::DIST_BITS'($unsigned(r_sqy));
    end

    assign o_tag  = r_tag4;
    assign o_dist = r_dist;

endmodule

// ----- tb/sv/nearest_seed_labeler_max_height_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_seed_labeler_max_height_checker
// Watches the command, config and result channels of the labeler. It keeps
// its own seed table and register copies, works out the label, seed and status
// fields for every command transaction it sees, and compares the strobed results
// in order against them.
// ----------------------------------------------------------------------------
module nearest_seed_labeler_max_height_checker
    import nsl_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [OPCODE_BITS-1:0]        i_opcode,
    input  logic [SIDX_BITS-1:0]          i_seed_index,
    input  logic signed [COORD_BITS-1:0]  i_coord_x,
    input  logic signed [COORD_BITS-1:0]  i_coord_y,
    input  logic signed [COORD_BITS-1:0]  i_coord_z,
    input  logic                          i_result_strobe,
    input  logic [LABEL_BITS-1:0]         i_tree_label,
    input  logic signed [COORD_BITS-1:0]  i_seed_x,
    input  logic signed [COORD_BITS-1:0]  i_seed_y,
    input  logic signed [COORD_BITS-1:0]  i_seed_height,
    input  logic [STATUS_BITS-1:0]        i_status,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [LABEL_BITS-1:0]        label;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] h;
        t_status                      status;
    } t_label_result;

    // own copy of the seed table and registers
    logic signed [COORD_BITS-1:0] seed_x [MAX_SEEDS];
    logic signed [COORD_BITS-1:0] seed_y [MAX_SEEDS];
    logic signed [COORD_BITS-1:0] seed_h [MAX_SEEDS];
    logic [COUNT_BITS-1:0]        seed_count_q   = '0;
    logic                         label_base_q   = 1'b0;
    logic                         height_raise_q = 1'b1;

    t_label_result pending_labels [$];
    t_label_result want;
    int            fails   = 0;
    int            checked = 0;

    assign o_fail_count = fails;
    assign o_checked    = checked;

    // exact squared planar distance, wide enough for opposite corners
    function automatic logic [DIST_BITS-1:0] planar_dist_sq(
        input logic signed [COORD_BITS-1:0] px,
        input logic signed [COORD_BITS-1:0] py,
        input logic signed [COORD_BITS-1:0] sx,
        input logic signed [COORD_BITS-1:0] sy
    );
        logic [DX_BITS-1:0]   dx;
        logic [DX_BITS-1:0]   dy;
        logic [DX_BITS-1:0]   mx;
        logic [DX_BITS-1:0]   my;
        logic [DIST_BITS-1:0] ax;
        logic [DIST_BITS-1:0] ay;
        logic [DIST_BITS-1:0] sum;
        dx  = {px[COORD_BITS-1], px} - {sx[COORD_BITS-1], sx};
        dy  = {py[COORD_BITS-1], py} - {sy[COORD_BITS-1], sy};
        mx  = dx[DX_BITS-1] ? -dx : dx;
        my  = dy[DX_BITS-1] ? -dy : dy;
        ax  = mx;
        ay  = my;
        sum = ax * ax + ay * ay;
        return sum;
    endfunction

    // result of one command, applied to the table copy
    function automatic t_label_result label_command(
        input logic [OPCODE_BITS-1:0]       op,
        input logic [SIDX_BITS-1:0]         idx,
        input logic signed [COORD_BITS-1:0] px,
        input logic signed [COORD_BITS-1:0] py,
        input logic signed [COORD_BITS-1:0] pz
    );
        t_label_result        r;
        int                   n;
        int                   best;
        int                   j;
        int                   label_sum;
        logic [DIST_BITS-1:0] best_d;
        logic [DIST_BITS-1:0] d;
        r = '0;
        n = (seed_count_q > MAX_SEEDS) ? MAX_SEEDS : int'(seed_count_q);
        case (op)
            OP_LOAD: begin
                if (int'(idx) < MAX_SEEDS) begin
                    seed_x[idx] = px;
                    seed_y[idx] = py;
                    seed_h[idx] = pz;
                    r.x = px;
                    r.y = py;
                    r.h = pz;
                end else begin
                    r.status = ST_RANGE;
                end
            end
            OP_CLASSIFY: begin
                if (n == 0) begin
                    r.status = ST_NO_SEEDS;
                end else begin
                    // strict compare keeps the lower index on a tie
                    best   = 0;
                    best_d = planar_dist_sq(px, py, seed_x[0], seed_y[0]);
                    for (j = 1; j < n; j++) begin
                        d = planar_dist_sq(px, py, seed_x[j], seed_y[j]);
                        if (d < best_d) begin
                            best_d = d;
                            best   = j;
                        end
                    end
                    if (height_raise_q && seed_h[best] < pz)
                        seed_h[best] = pz;
                    label_sum = best + int'(label_base_q);
                    r.label   = label_sum[LABEL_BITS-1:0];
                    r.x       = seed_x[best];
                    r.y       = seed_y[best];
                    r.h       = seed_h[best];
                end
            end
            OP_READ: begin
                if (int'(idx) >= n) begin
                    r.status = ST_RANGE;
                end else begin
                    r.x = seed_x[idx];
                    r.y = seed_y[idx];
                    r.h = seed_h[idx];
                end
            end
            default: begin
                // unused opcode: all fields zero, nothing changes
            end
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        fails++;
        if (fails <= REPORT_LIMIT)
            $display("[%0t] %s", $time, msg);
    endtask

    task automatic check_field(
        input string             field,
        input logic signed [31:0] want_v,
        input logic signed [31:0] got_v
    );
        if (got_v !== want_v)
            flag_mismatch($sformatf("result %0d, %s: expected %0d, got %0d",
                                    checked, field, want_v, got_v));
    endtask

    // watch all three channels at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seed_count_q   = '0;
            label_base_q   = 1'b0;
            height_raise_q = 1'b1;
            pending_labels.delete();
        end else begin
            // results first: none can belong to a command taken at this edge
            if (i_result_strobe) begin
                if (pending_labels.size() == 0) begin
                    flag_mismatch("result strobe with no command outstanding");
                end else begin
                    want = pending_labels.pop_front();
                    check_field("tree_label", want.label, i_tree_label);
                    check_field("seed_x", $signed(want.x), i_seed_x);
                    check_field("seed_y", $signed(want.y), i_seed_y);
                    check_field("seed_height", $signed(want.h), i_seed_height);
                    check_field("status", want.status, i_status);
                    checked++;
                end
            end

            // register write transaction
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SEED_COUNT: seed_count_q   = i_cfg_data[COUNT_BITS-1:0];
                    CFG_LABEL_BASE: label_base_q   = i_cfg_data[0];
                    CFG_HEIGHT_UPD: height_raise_q = i_cfg_data[0];
                    default: begin
                        // no register behind this index
                    end
                endcase
            end

            // command transaction, queued behind the ones still outstanding
            if (i_start && !i_busy)
                pending_labels = {pending_labels,
                                  label_command(i_opcode, i_seed_index,
                                                i_coord_x, i_coord_y, i_coord_z)};
        end
        o_pending <= pending_labels.size();
    end

endmodule

// ----- tb/sv/nearest_seed_labeler_max_height_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_seed_labeler_max_height_tb
// Drives load, classify, read and unused commands into the labeler across a
// series of seed count, label base and height update settings, with random
// gaps between transactions. The checker beside the block predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module nearest_seed_labeler_max_height_tb;
    import nsl_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int MAX_GAP      = 5;

    localparam logic [OPCODE_BITS-1:0]     OP_UNUSED       = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0]    CFG_SPARE       = 2'd3;
    localparam logic [CFG_DATA_BITS-1:0]   COUNT_FIELD_MAX = '1;
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic                          i_clk             = 1'b0;
    logic                          i_rst_n           = 1'b0;
    logic                          start             = 1'b0;
    logic                          busy;
    logic [OPCODE_BITS-1:0]        i_opcode          = '0;
    logic [SIDX_BITS-1:0]          i_seed_index      = '0;
    logic signed [COORD_BITS-1:0]  i_coord_x         = '0;
    logic signed [COORD_BITS-1:0]  i_coord_y         = '0;
    logic signed [COORD_BITS-1:0]  i_coord_z         = '0;
    logic                          o_result_strobe;
    logic [LABEL_BITS-1:0]         o_tree_label;
    logic signed [COORD_BITS-1:0]  o_seed_x_out;
    logic signed [COORD_BITS-1:0]  o_seed_y_out;
    logic signed [COORD_BITS-1:0]  o_seed_height_out;
    logic [STATUS_BITS-1:0]        o_status;
    logic                          i_cfg_valid       = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]       i_cfg_index       = '0;
    logic [CFG_DATA_BITS-1:0]      i_cfg_data        = '0;

    int fail_count;
    int results_pending;
    int results_checked;
    int cycle_count   = 0;
    int gap_ceiling   = MAX_GAP;
    int cluster_center = 0;
    int n_loads       = 0;
    int n_classifies  = 0;
    int n_reads       = 0;
    int n_unused      = 0;
    int n_reg_writes  = 0;
    bit seed_loaded [MAX_SEEDS];

    nearest_seed_labeler_max_height dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_seed_index      (i_seed_index),
        .i_coord_x         (i_coord_x),
        .i_coord_y         (i_coord_y),
        .i_coord_z         (i_coord_z),
        .o_result_strobe   (o_result_strobe),
        .o_tree_label      (o_tree_label),
        .o_seed_x_out      (o_seed_x_out),
        .o_seed_y_out      (o_seed_y_out),
        .o_seed_height_out (o_seed_height_out),
        .o_status          (o_status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    nearest_seed_labeler_max_height_checker labeler_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_opcode        (i_opcode),
        .i_seed_index    (i_seed_index),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_coord_z       (i_coord_z),
        .i_result_strobe (o_result_strobe),
        .i_tree_label    (o_tree_label),
        .i_seed_x        (o_seed_x_out),
        .i_seed_y        (o_seed_y_out),
        .i_seed_height   (o_seed_height_out),
        .i_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (results_pending),
        .o_checked       (results_checked)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles, %0d results outstanding",
                     cycle_count, results_pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // coordinate mix: full range, a cluster around a moving center, tiny
    // values that tie often, and the corners of the range plus zero and minus one
    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        int unsigned pick;
        logic [31:0] raw;
        int          near;
        int          tiny;
        pick = $urandom_range(0, 99);
        raw  = $urandom;
        near = cluster_center + int'($urandom_range(0, 8191)) - 4096;
        tiny = int'($urandom_range(0, 16)) - 8;
        if (pick < 35)
            return raw[COORD_BITS-1:0];
        if (pick < 70)
            return near[COORD_BITS-1:0];
        if (pick < 88)
            return tiny[COORD_BITS-1:0];
        case (raw[1:0])
            2'd0:    return COORD_MIN;
            2'd1:    return COORD_MAX;
            2'd2:    return '0;
            default: return '1;
        endcase
    endfunction

    // one command transaction, then a random gap
    task automatic issue_command(
        input logic [OPCODE_BITS-1:0]       op,
        input int                           idx,
        input logic signed [COORD_BITS-1:0] x,
        input logic signed [COORD_BITS-1:0] y,
        input logic signed [COORD_BITS-1:0] z
    );
        int gap;
        i_opcode     <= op;
        i_seed_index <= idx[SIDX_BITS-1:0];
        i_coord_x    <= x;
        i_coord_y    <= y;
        i_coord_z    <= z;
        start        <= 1'b1;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        case (op)
            OP_LOAD: begin
                seed_loaded[idx[SIDX_BITS-1:0]] = 1'b1;
                n_loads++;
            end
            OP_CLASSIFY: n_classifies++;
            OP_READ:     n_reads++;
            default:     n_unused++;
        endcase
        gap = $urandom_range(0, gap_ceiling);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop issuing and let every outstanding result come back
    task automatic wait_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(
        input logic [CFG_IDX_BITS-1:0]  idx,
        input logic [CFG_DATA_BITS-1:0] data
    );
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        n_reg_writes++;
        repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
    endtask

    // all three registers, written while the block is idle; flag registers
    // get random upper data bits
    task automatic configure(input int count, input logic base, input logic raise);
        logic [CFG_DATA_BITS-2:0] junk_a;
        logic [CFG_DATA_BITS-2:0] junk_b;
        junk_a = (CFG_DATA_BITS-1)'($urandom);
        junk_b = (CFG_DATA_BITS-1)'($urandom);
        wait_until_drained();
        write_reg(CFG_SEED_COUNT, count[CFG_DATA_BITS-1:0]);
        write_reg(CFG_LABEL_BASE, {junk_a, base});
        write_reg(CFG_HEIGHT_UPD, {junk_b, raise});
    endtask

    // stimulus
    initial begin : stimulus
        int   random_items;
        int   phase;
        int   seed_cfg;
        int   active;
        int   n_items;
        int   pick;
        int   idx;
        int   k;
        int   j;
        logic base_sel;
        logic raise_sel;
        random_items = 0;
        phase        = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: classify and read both refused, unused opcode ignored
        issue_command(OP_CLASSIFY, 0, '0, '0, '0);
        issue_command(OP_READ, 0, '0, '0, '0);
        issue_command(OP_UNUSED, MAX_SEEDS - 1, '1, '1, '1);

        // corner seeds plus two seeds on the same spot
        issue_command(OP_LOAD, 0, COORD_MAX, COORD_MIN, COORD_MIN);
        issue_command(OP_LOAD, 1, COORD_MIN, COORD_MAX, COORD_MAX);
        issue_command(OP_LOAD, 2, '0, '0, '0);
        issue_command(OP_LOAD, 3, '0, '0, -24'sd5);
        issue_command(OP_LOAD, MAX_SEEDS - 1, '1, '1, COORD_MAX);

        wait_until_drained();
        write_reg(CFG_SPARE, COUNT_FIELD_MAX);
        write_reg(CFG_SEED_COUNT, 9'd4);

        // exact hit, height raise from the minimum, tie, widest distance
        issue_command(OP_CLASSIFY, 0, COORD_MIN, COORD_MAX, COORD_MAX);
        issue_command(OP_CLASSIFY, 0, COORD_MAX, COORD_MIN, COORD_MAX);
        issue_command(OP_CLASSIFY, 0, 24'sd1, 24'sd1, 24'sd100);
        issue_command(OP_CLASSIFY, 0, COORD_MIN, COORD_MIN, '0);
        issue_command(OP_READ, 3, '0, '0, '0);
        issue_command(OP_READ, 4, '0, '0, '0);

        // label base one, height update off
        configure(4, 1'b1, 1'b0);
        issue_command(OP_CLASSIFY, 0, '0, '0, COORD_MAX);
        issue_command(OP_READ, 2, '0, '0, '0);
        issue_command(OP_READ, MAX_SEEDS - 1, '0, '0, '0);

        // random phases, each with its own settings
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (phase == 3)
                seed_cfg = MAX_SEEDS;
            else if (phase == 6)
                seed_cfg = int'(COUNT_FIELD_MAX);
            else if (pick < 6)
                seed_cfg = 0;
            else if (pick < 9)
                seed_cfg = MAX_SEEDS;
            else if (pick < 11)
                seed_cfg = $urandom_range(MAX_SEEDS + 1, int'(COUNT_FIELD_MAX));
            else if (pick < 20)
                seed_cfg = 1;
            else
                seed_cfg = $urandom_range(2, 24);
            active    = (seed_cfg > MAX_SEEDS) ? MAX_SEEDS : seed_cfg;
            base_sel  = (phase == 6) ? 1'b1 : 1'($urandom_range(0, 1));
            raise_sel = ($urandom_range(0, 9) < 7);
            configure(seed_cfg, base_sel, raise_sel);

            gap_ceiling    = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
            cluster_center = int'($urandom_range(0, 1 << 23)) - (1 << 22);

            // searched entries must hold seeds; small tables get fresh ones
            for (k = 0; k < active; k++) begin
                if (!seed_loaded[k] || (active <= 32 && $urandom_range(0, 1) == 1)) begin
                    issue_command(OP_LOAD, k, rand_coord(), rand_coord(), rand_coord());
                    random_items++;
                end
            end

            // last entry wins, label reaches its top value
            if (phase == 6) begin
                issue_command(OP_LOAD, MAX_SEEDS - 1, COORD_MAX, COORD_MAX, COORD_MIN);
                issue_command(OP_CLASSIFY, 0, COORD_MAX, COORD_MAX, COORD_MAX);
                issue_command(OP_READ, MAX_SEEDS - 1, '0, '0, '0);
                random_items += 3;
            end

            n_items = (active > 32) ? $urandom_range(3, 6) : $urandom_range(10, 40);
            for (j = 0; j < n_items; j++) begin
                pick = $urandom_range(0, 99);
                if (pick < 58) begin
                    issue_command(OP_CLASSIFY, $urandom_range(0, MAX_SEEDS - 1),
                                  rand_coord(), rand_coord(), rand_coord());
                    random_items++;
                end else if (pick < 76) begin
                    idx = (active > 0 && $urandom_range(0, 3) != 0) ?
                          $urandom_range(0, active - 1) : $urandom_range(0, MAX_SEEDS - 1);
                    issue_command(OP_LOAD, idx, rand_coord(), rand_coord(), rand_coord());
                    random_items++;
                end else if (pick < 95) begin
                    idx = (active > 0 && $urandom_range(0, 9) < 7) ?
                          $urandom_range(0, active - 1) : $urandom_range(0, MAX_SEEDS - 1);
                    issue_command(OP_READ, idx, rand_coord(), rand_coord(), rand_coord());
                    random_items++;
                end else begin
                    issue_command(OP_UNUSED, $urandom_range(0, MAX_SEEDS - 1),
                                  rand_coord(), rand_coord(), rand_coord());
                    random_items++;
                end
            end
            phase++;
        end

        // drain, then allow for a full scan in case anything stray follows
        wait_until_drained();
        repeat (MAX_SEEDS + 16) @(posedge i_clk);

        $display("%0d phases: %0d loads, %0d classifies, %0d reads, %0d unused opcodes, %0d reg writes",
                 phase, n_loads, n_classifies, n_reads, n_unused, n_reg_writes);
        $display("%0d results compared field by field, %0d mismatches",
                 results_checked, fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- nearest_seed_labeler_max_height.f -----
rtl/nsl_pkg.sv
rtl/nsl_ram.sv
rtl/nsl_dist_pipe.sv
rtl/nearest_seed_labeler_max_height.sv
tb/sv/nearest_seed_labeler_max_height_checker.sv
tb/sv/nearest_seed_labeler_max_height_tb.sv
